[src/gpik_pkg.sv]
// Shared types and constants for the gimbal pan/tilt inverse kinematics unit.
// Depends on nothing; imported by every module of the block.
package gpik_pkg;

  // CORDIC datapath word: x/y carry the vector, ang the accumulated turn.
  localparam int CW         = 34;
  localparam int AW         = 32;
  localparam int STEPS      = 32;
  localparam int NORM_BITS  = 30;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [AW-1:0] QTR_POS = 32'h4000_0000;
  localparam logic [AW-1:0] QTR_NEG = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [AW-1:0] TURN_TAB [STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]        ang;
  } gpik_vec_t;

endpackage

[src/gpik_cordic_cell.sv]
// One CORDIC vectoring step, registered; a row of these forms the angle chain.
// Depends on gpik_pkg (vector type and turn table).
module gpik_cordic_cell import gpik_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk_i,
  input  gpik_vec_t vec_i,
  output gpik_vec_t vec_o
);

  logic signed [CW-1:0] dx, dy;
  gpik_vec_t vec_d, vec_q;

  always_comb begin
    dx = vec_i.y >>> STEP;
    dy = vec_i.x >>> STEP;
    // rotate towards the x axis
    if (!vec_i.y[CW-1]) begin
      vec_d.x   = vec_i.x + dx;
      vec_d.y   = vec_i.y - dy;
      vec_d.ang = vec_i.ang + TURN_TAB[STEP];
    end else begin
      vec_d.x   = vec_i.x - dx;
      vec_d.y   = vec_i.y + dy;
      vec_d.ang = vec_i.ang - TURN_TAB[STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

[src/gimbal_pan_tilt_inverse_kinematics_unit.sv]
// Top level of the gimbal pan/tilt inverse kinematics unit.
// Depends on gpik_pkg and gpik_cordic_cell.
//
// Usage:
//  - Input channel: drive dir_x_i, dir_y_i, dir_z_i and raise start_i; the
//    word is taken at the rising edge where start_i is high and busy_o low.
//    busy_o stays low: a new word is taken in every cycle.
//  - Result channel: done_o is high for one cycle with pan_angle_o,
//    tilt_angle_o and status_o; the word is taken at the edge ending it.
//    The receiver cannot stall, so there is no back-pressure anywhere.
//  - Throughput: one word per cycle, fixed by the pipeline from the
//    accepting edge to the edge taking the result: input register,
//    multipliers, adder, shift search, normalise and quarter turn,
//    32 CORDIC cells per angle, output rounding.
//  - pan = atan2(x, z); tilt = atan2(y*z, x^2 + z^2). Both angles run in
//    two parallel, identical rows of CORDIC cells.
//  - x = z = 0 gives status 1 and zero angles.
//  - Reset clears every valid bit; words in flight are dropped.
module gimbal_pan_tilt_inverse_kinematics_unit import gpik_pkg::*; #(
  parameter int VECTOR_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [VECTOR_BITS-1:0] dir_x_i,
  input  logic signed [VECTOR_BITS-1:0] dir_y_i,
  input  logic signed [VECTOR_BITS-1:0] dir_z_i,
  output logic                          done_o,
  output logic signed [ANGLE_BITS-1:0]  pan_angle_o,
  output logic signed [ANGLE_BITS-1:0]  tilt_angle_o,
  output logic [1:0]                    status_o
);

  localparam int VB = VECTOR_BITS;
  localparam int PW = 2 * VECTOR_BITS;
  localparam int SW = $clog2(PW + 1);
  localparam int RS = AW - ANGLE_BITS;

  // stage 0: input register
  logic                 v0_q, deg0_q;
  logic signed [VB-1:0] x0_q, y0_q, z0_q;

  // stage 1: magnitudes and products
  logic          v1_q, deg1_q, xneg1_q, zneg1_q, uneg1_q;
  logic [VB-1:0] mx0, my0, mz0, mx1_q, mz1_q;
  logic [PW-1:0] u1_q, xx1_q, zz1_q;

  // stages 2..4: lane 0 is pan, lane 1 is tilt
  logic          v2_q, deg2_q, v3_q, deg3_q, v4_q, deg4_q;
  logic [PW-1:0] num2_q [2], den2_q [2], num3_q [2], den3_q [2];
  logic          nneg2_q [2], dneg2_q [2], nneg3_q [2], dneg3_q [2];
  logic [SW-1:0] sh_d [2], sh3_q [2];
  gpik_vec_t     vec_d [2], vec4_q [2];

  // CORDIC rows and their valid line
  gpik_vec_t         chain [2][STEPS+1];
  logic [STEPS-1:0]  val_line_q, deg_line_q;
  logic [AW-1:0]     rnd [2];

  logic                        done_q;
  logic signed [ANGLE_BITS-1:0] pan_q, tilt_q;
  logic [1:0]                   status_q;

  assign busy_o = 1'b0;

  // Control: valid flags through the front stages, the CORDIC valid line and done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      val_line_q <= '0;
      done_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      val_line_q <= {val_line_q[STEPS-2:0], v4_q};
      done_q <= val_line_q[STEPS-1];
    end
  end

  assign mx0 = x0_q[VB-1] ? VB'(-x0_q) : VB'(x0_q);
  assign my0 = y0_q[VB-1] ? VB'(-y0_q) : VB'(y0_q);
  assign mz0 = z0_q[VB-1] ? VB'(-z0_q) : VB'(z0_q);

  // Payload and degenerate flags of the front stages, and the degenerate line
  always_ff @(posedge clk_i) begin
    x0_q   <= dir_x_i;
    y0_q   <= dir_y_i;
    z0_q   <= dir_z_i;
    deg0_q <= (dir_x_i == '0) && (dir_z_i == '0);

    deg1_q  <= deg0_q;
    mx1_q   <= mx0;
    mz1_q   <= mz0;
    xneg1_q <= x0_q[VB-1];
    zneg1_q <= z0_q[VB-1];
    uneg1_q <= (y0_q != '0) && (z0_q != '0) && (y0_q[VB-1] != z0_q[VB-1]);
    u1_q    <= PW'(my0) * PW'(mz0);
    xx1_q   <= PW'(mx0) * PW'(mx0);
    zz1_q   <= PW'(mz0) * PW'(mz0);

    deg2_q     <= deg1_q;
    num2_q[0]  <= PW'(mx1_q);
    den2_q[0]  <= PW'(mz1_q);
    nneg2_q[0] <= xneg1_q;
    dneg2_q[0] <= zneg1_q;
    num2_q[1]  <= u1_q;
    den2_q[1]  <= xx1_q + zz1_q;
    nneg2_q[1] <= uneg1_q;
    dneg2_q[1] <= 1'b0;

    deg3_q <= deg2_q;
    num3_q <= num2_q;
    den3_q <= den2_q;
    nneg3_q <= nneg2_q;
    dneg3_q <= dneg2_q;
    sh3_q   <= sh_d;

    deg4_q <= deg3_q;
    vec4_q <= vec_d;

    deg_line_q <= {deg_line_q[STEPS-2:0], deg4_q};
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [PW-1:0]        w;
    logic [NORM_BITS-1:0] nm, dm;
    logic signed [CW-1:0] n, d;

    // shift search: bring both magnitudes below 2^NORM_BITS
    always_comb begin
      w       = num2_q[l] | den2_q[l];
      sh_d[l] = '0;
      for (int i = 0; i < PW; i++) begin
        if (w[i] && i >= NORM_BITS - 1) begin
          sh_d[l] = SW'(i - NORM_BITS + 1);
        end
      end
    end

    // normalise, restore sign, fold the left half plane by a quarter turn
    always_comb begin
      nm = NORM_BITS'(num3_q[l] >> sh3_q[l]);
      dm = NORM_BITS'(den3_q[l] >> sh3_q[l]);
      n  = nneg3_q[l] ? -CW'($signed({1'b0, nm})) : CW'($signed({1'b0, nm}));
      d  = dneg3_q[l] ? -CW'($signed({1'b0, dm})) : CW'($signed({1'b0, dm}));
      if (d[CW-1]) begin
        if (!n[CW-1]) begin
          vec_d[l].x   = n;
          vec_d[l].y   = -d;
          vec_d[l].ang = QTR_POS;
        end else begin
          vec_d[l].x   = -n;
          vec_d[l].y   = d;
          vec_d[l].ang = QTR_NEG;
        end
      end else begin
        vec_d[l].x   = d;
        vec_d[l].y   = n;
        vec_d[l].ang = '0;
      end
    end

    assign chain[l][0] = vec4_q[l];

    for (genvar s = 0; s < STEPS; s++) begin : g_cell
      gpik_cordic_cell #(.STEP(s)) u_cell (
        .clk_i (clk_i),
        .vec_i (chain[l][s]),
        .vec_o (chain[l][s+1])
      );
    end

    // round half up to the output angle width
    if (RS == 0) begin : g_nornd
      assign rnd[l] = chain[l][STEPS].ang;
    end else begin : g_rnd
      assign rnd[l] = (chain[l][STEPS].ang + (AW'(1) << (RS - 1))) >> RS;
    end
  end

  // Output register: hold the word for its single strobe cycle
  always_ff @(posedge clk_i) begin
    if (deg_line_q[STEPS-1]) begin
      pan_q    <= '0;
      tilt_q   <= '0;
      status_q <= ST_DEGEN;
    end else begin
      pan_q    <= ANGLE_BITS'(rnd[0]);
      tilt_q   <= ANGLE_BITS'(rnd[1]);
      status_q <= ST_OK;
    end
  end

  assign done_o       = done_q;
  assign pan_angle_o  = pan_q;
  assign tilt_angle_o = tilt_q;
  assign status_o     = status_q;

endmodule

[src/gpik_checker.sv]
// Port-level checks for the gimbal pan/tilt inverse kinematics unit.
// Depends on gpik_pkg; bound to the top level below.
module gpik_checker import gpik_pkg::*; #(
  parameter int VECTOR_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [VECTOR_BITS-1:0] dir_x_i,
  input logic signed [VECTOR_BITS-1:0] dir_y_i,
  input logic signed [VECTOR_BITS-1:0] dir_z_i,
  input logic                          done_o,
  input logic signed [ANGLE_BITS-1:0]  pan_angle_o,
  input logic signed [ANGLE_BITS-1:0]  tilt_angle_o,
  input logic [1:0]                    status_o
);

  localparam logic signed [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));

  // pipeline never holds the sender off
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  a_no_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != ST_RANGE) else $error("unexpected status code");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_DEGEN |-> pan_angle_o == '0 && tilt_angle_o == '0)
    else $error("degenerate word with nonzero angles");

  a_tilt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_OK |-> tilt_angle_o <= QTR && tilt_angle_o >= -QTR)
    else $error("tilt outside a quarter turn");

endmodule

bind gimbal_pan_tilt_inverse_kinematics_unit gpik_checker #(
  .VECTOR_BITS (VECTOR_BITS),
  .ANGLE_BITS  (ANGLE_BITS)
) u_gpik_checker (.*);
